/* rtl/core/piv_pkg.sv */
package piv_pkg;

    localparam int CMD_BYTES = 32;
    localparam int CMD_AW    = $clog2(CMD_BYTES);
    localparam int PARSE_BYTES = 18;
    localparam logic [16:0] LEN_TOP = 17'h1FFFF;

    localparam logic [7:0] INS_SELECT   = 8'hA4;
    localparam logic [7:0] INS_GET_DATA = 8'hCB;
    localparam logic [7:0] INS_GET_RESP = 8'hC0;
    localparam logic [7:0] INS_VERIFY   = 8'h20;
    localparam logic [7:0] INS_CHANGE   = 8'h24;
    localparam logic [7:0] INS_GEN_AUTH = 8'h87;
    localparam logic [7:0] TAG_LIST     = 8'h5C;

    localparam logic [15:0] SW_OK         = 16'h9000;
    localparam logic [7:0]  SW_MORE_HI    = 8'h61;
    localparam logic [15:0] SW_WRONG_LEN  = 16'h6700;
    localparam logic [15:0] SW_COND       = 16'h6985;
    localparam logic [15:0] SW_BAD_DATA   = 16'h6A80;
    localparam logic [15:0] SW_NOT_FOUND  = 16'h6A82;
    localparam logic [15:0] SW_BAD_P1P2   = 16'h6A86;
    localparam logic [15:0] SW_NO_OBJECT  = 16'h6A88;
    localparam logic [15:0] SW_BAD_INS    = 16'h6D00;
    localparam logic [15:0] SW_BAD_CLA    = 16'h6E00;

    typedef enum logic [2:0] {
        OBJ_NONE  = 3'd0,
        OBJ_PROP  = 3'd1,
        OBJ_DISC  = 3'd2,
        OBJ_CHUID = 3'd3,
        OBJ_CCC   = 3'd4,
        OBJ_KHIST = 3'd5
    } obj_t;

    localparam logic [7:0] PIV_AID [11] = '{8'hA0, 8'h00, 8'h00, 8'h03, 8'h08, 8'h00,
        8'h00, 8'h10, 8'h00, 8'h01, 8'h00};
    localparam logic [7:0] OBJ_PROP_B [19] = '{8'h61, 8'h11, 8'h4F, 8'h06, 8'h00, 8'h00,
        8'h10, 8'h00, 8'h01, 8'h00, 8'h79, 8'h07, 8'h4F, 8'h05, 8'hA0, 8'h00, 8'h00,
        8'h03, 8'h08};
    localparam logic [7:0] OBJ_DISC_B [20] = '{8'h7E, 8'h12, 8'h4F, 8'h0B, 8'hA0, 8'h00,
        8'h00, 8'h03, 8'h08, 8'h00, 8'h00, 8'h10, 8'h00, 8'h01, 8'h00, 8'h5F, 8'h2F,
        8'h02, 8'h40, 8'h00};
    localparam logic [7:0] OBJ_CCC_B [38] = '{8'h53, 8'h24, 8'hF0, 8'h15, 8'hA0, 8'h00,
        8'h00, 8'h01, 8'h16, 8'hFF, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'hF1, 8'h01, 8'h21, 8'hF2,
        8'h01, 8'h21, 8'hF3, 8'h00, 8'hF4, 8'h01, 8'h00, 8'hF5, 8'h01, 8'h10};
    localparam logic [7:0] OBJ_KHIST_B [11] = '{8'h53, 8'h09, 8'hC1, 8'h01, 8'h00, 8'hC2,
        8'h01, 8'h00, 8'hC3, 8'h01, 8'h00};
    // GUID bytes 31..46 are filled from the registers at read time
    localparam logic [7:0] OBJ_CHUID_B [61] = '{8'h53, 8'h3B,
        8'h30, 8'h19, 8'hD4, 8'hE7, 8'h39, 8'hDA, 8'h73, 8'h9C, 8'hED, 8'h39, 8'hCE,
        8'h73, 8'h9D, 8'h83, 8'h68, 8'h58, 8'h21, 8'h08, 8'h42, 8'h10, 8'h84, 8'h21,
        8'hC8, 8'h42, 8'h10, 8'hC3, 8'hEB,
        8'h34, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h35, 8'h08, 8'h32, 8'h30, 8'h34, 8'h36, 8'h30, 8'h31, 8'h30, 8'h31,
        8'h3E, 8'h00, 8'hFE, 8'h00};

    typedef struct packed {
        obj_t       obj;
        logic [7:0] start;
        logic [7:0] left;
    } pend_t;

    typedef struct packed {
        logic        kill;      // capacity below two: response dropped
        logic        emit;
        obj_t        obj;
        logic [7:0]  start;
        logic [8:0]  len;
        logic [15:0] status;
        logic        pend_we;
        pend_t       pend;
    } decision_t;

    function automatic logic [8:0] obj_len(obj_t obj);
        logic [8:0] n;
        case (obj)
            OBJ_PROP:  n = 9'd19;
            OBJ_DISC:  n = 9'd20;
            OBJ_CHUID: n = 9'd61;
            OBJ_CCC:   n = 9'd38;
            OBJ_KHIST: n = 9'd11;
            default:   n = 9'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] obj_byte(obj_t obj, logic [9:0] idx,
                                            logic [63:0] gh, logic [63:0] gl);
        logic [7:0] b;
        logic [2:0] k;
        b = 8'h00;
        k = 3'(idx - 10'd31);
        if ({1'b0, idx} < {2'b0, obj_len(obj)}) begin
            case (obj)
                OBJ_PROP:  b = OBJ_PROP_B[idx[4:0]];
                OBJ_DISC:  b = OBJ_DISC_B[idx[4:0]];
                OBJ_CCC:   b = OBJ_CCC_B[idx[5:0]];
                OBJ_KHIST: b = OBJ_KHIST_B[idx[3:0]];
                OBJ_CHUID:
                begin
                    if (idx >= 10'd31 && idx < 10'd39) begin
                        b = gh[{3'(3'd7 - k), 3'b000} +: 8];
                    end else if (idx >= 10'd39 && idx < 10'd47) begin
                        b = gl[{3'(3'd7 - 3'(idx - 10'd39)), 3'b000} +: 8];
                    end else begin
                        b = OBJ_CHUID_B[idx[5:0]];
                    end
                end
                default:   b = 8'h00;
            endcase
        end
        return b;
    endfunction

endpackage

/* rtl/core/piv_cmd_decode.sv */
module piv_cmd_decode (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr,
    input  logic [7:0]            cmd_byte,
    input  logic                  cmd_last,
    input  logic [12:0]           capacity,
    input  piv_pkg::pend_t        pend,
    output piv_pkg::decision_t    dec
);
    import piv_pkg::*;

    logic [7:0]  store_reg [CMD_BYTES];
    logic [16:0] len_reg, len_next;
    logic [15:0] tail_reg, tail_next;

    logic [16:0] len;
    logic [15:0] tail;
    logic [7:0]  cb [PARSE_BYTES];
    logic [7:0]  d  [11];
    logic [15:0] lc;
    logic [16:0] le;
    logic        ok, off7;
    logic [17:0] len18;
    logic [12:0] room;
    logic        use_reply;
    obj_t        robj;
    logic [8:0]  olen, take, rest;
    logic [7:0]  g_take, g_left;
    logic        aid11, aid9;

    assign len  = (len_reg < LEN_TOP) ? len_reg + 17'd1 : len_reg;
    assign tail = {tail_reg[7:0], cmd_byte};

    always_comb
    begin
        len_next  = cmd_last ? 17'd0 : len;
        tail_next = cmd_last ? 16'd0 : tail;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            len_reg  <= '0;
            tail_reg <= '0;
        end else if (wr) begin
            len_reg  <= len_next;
            tail_reg <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr && len_reg < 17'(CMD_BYTES)) begin
            store_reg[len_reg[CMD_AW-1:0]] <= cmd_byte;
        end
    end

    // header bytes with the byte now arriving bypassed in
    always_comb
    begin
        for (int i = 0; i < PARSE_BYTES; i++) begin
            cb[i] = (len_reg == 17'(i)) ? cmd_byte : store_reg[i];
        end
    end

    always_comb
    begin
        ok   = 1'b0;
        lc   = '0;
        le   = '0;
        off7 = 1'b0;
        len18 = {1'b0, len};
        if (len == 17'd4) begin
            ok = 1'b1;
        end else if (len == 17'd5) begin
            le = (cb[4] != 8'd0) ? {9'd0, cb[4]} : 17'd256;
            ok = 1'b1;
        end else if (len > 17'd5 && cb[4] != 8'd0) begin
            lc = {8'd0, cb[4]};
            if (len18 == {2'b0, lc} + 18'd5) begin
                ok = 1'b1;
            end else if (len18 == {2'b0, lc} + 18'd6) begin
                le = (tail[7:0] != 8'd0) ? {9'd0, tail[7:0]} : 17'd256;
                ok = 1'b1;
            end
        end else if (len == 17'd7) begin
            le = (tail != 16'd0) ? {1'b0, tail} : 17'h10000;
            ok = 1'b1;
        end else if (len > 17'd7) begin
            lc   = {cb[5], cb[6]};
            off7 = 1'b1;
            if (len18 == {2'b0, lc} + 18'd7) begin
                ok = 1'b1;
            end else if (len18 == {2'b0, lc} + 18'd9) begin
                le = (tail != 16'd0) ? {1'b0, tail} : 17'h10000;
                ok = 1'b1;
            end
        end
        if (!ok) begin
            lc = '0;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 11; i++) begin
            d[i] = off7 ? cb[7 + i] : cb[5 + i];
        end
    end

    always_comb
    begin
        aid9 = 1'b1;
        for (int i = 0; i < 9; i++) begin
            if (d[i] != PIV_AID[i]) aid9 = 1'b0;
        end
        aid11 = aid9 && d[9] == PIV_AID[9] && d[10] == PIV_AID[10] && lc == 16'd11;
        aid9  = aid9 && lc == 16'd9;
    end

    assign room = capacity - 13'd2;

    always_comb
    begin
        olen = obj_len(robj);
        take = olen;
        if (le != 17'd0 && {8'd0, take} > le) take = le[8:0];
        if ({4'd0, take} > room) take = room[8:0];
        rest = olen - take;

        g_take = pend.left;
        if (le != 17'd0 && {9'd0, g_take} > le) g_take = le[7:0];
        if ({5'd0, g_take} > room) g_take = room[7:0];
        g_left = pend.left - g_take;
    end

    always_comb
    begin
        dec       = '0;
        use_reply = 1'b0;
        robj      = OBJ_NONE;
        if (wr && cmd_last) begin
            if (capacity < 13'd2) begin
                dec.kill = 1'b1;
            end else if (!ok) begin
                dec.emit   = 1'b1;
                dec.status = SW_WRONG_LEN;
            end else if (cb[0] != 8'd0) begin
                dec.emit   = 1'b1;
                dec.status = SW_BAD_CLA;
            end else begin
                dec.emit = 1'b1;
                if (cb[1] != INS_GET_RESP) begin
                    dec.pend_we = 1'b1;
                end
                unique case (cb[1])
                    INS_SELECT:
                    begin
                        if (aid11 || aid9) begin
                            use_reply = 1'b1;
                            robj      = OBJ_PROP;
                        end else begin
                            dec.status = SW_NOT_FOUND;
                        end
                    end
                    INS_GET_DATA:
                    begin
                        if (cb[2] != 8'h3F || cb[3] != 8'hFF) begin
                            dec.status = SW_BAD_P1P2;
                        end else if (lc < 16'd3 || d[0] != TAG_LIST) begin
                            dec.status = SW_BAD_DATA;
                        end else if (lc == 16'd3 && d[1] == 8'd1 && d[2] == 8'h7E) begin
                            use_reply = 1'b1;
                            robj      = OBJ_DISC;
                        end else if (lc == 16'd5 && d[1] == 8'd3 && d[2] == 8'h5F
                                     && d[3] == 8'hC1 && d[4] == 8'h02) begin
                            use_reply = 1'b1;
                            robj      = OBJ_CHUID;
                        end else if (lc == 16'd5 && d[1] == 8'd3 && d[2] == 8'h5F
                                     && d[3] == 8'hC1 && d[4] == 8'h07) begin
                            use_reply = 1'b1;
                            robj      = OBJ_CCC;
                        end else if (lc == 16'd5 && d[1] == 8'd3 && d[2] == 8'h5F
                                     && d[3] == 8'hC1 && d[4] == 8'h0C) begin
                            use_reply = 1'b1;
                            robj      = OBJ_KHIST;
                        end else begin
                            dec.status = SW_NO_OBJECT;
                        end
                    end
                    INS_GET_RESP:
                    begin
                        if (pend.left == 8'd0) begin
                            dec.status = SW_COND;
                        end else begin
                            dec.obj     = pend.obj;
                            dec.start   = pend.start;
                            dec.len     = {1'b0, g_take};
                            dec.pend_we = 1'b1;
                            if (g_left == 8'd0) begin
                                dec.status = SW_OK;
                            end else begin
                                dec.status     = {SW_MORE_HI, g_left};
                                dec.pend.obj   = pend.obj;
                                dec.pend.start = pend.start + g_take;
                                dec.pend.left  = g_left;
                            end
                        end
                    end
                    INS_VERIFY, INS_CHANGE, INS_GEN_AUTH:
                    begin
                        dec.status = SW_COND;
                    end
                    default:
                    begin
                        dec.status = SW_BAD_INS;
                    end
                endcase
                if (use_reply) begin
                    dec.obj = robj;
                    dec.len = take;
                    if (rest == 9'd0) begin
                        dec.status = SW_OK;
                    end else begin
                        dec.status     = {SW_MORE_HI, rest[7:0]};
                        dec.pend.obj   = robj;
                        dec.pend.start = take[7:0];
                        dec.pend.left  = rest[7:0];
                    end
                end
            end
        end
    end

endmodule

/* rtl/core/piv_readout.sv */
module piv_readout (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rd,
    input  logic               out_stall,
    input  piv_pkg::decision_t dec,
    input  logic [63:0]        guid_high,
    input  logic [63:0]        guid_low,
    output piv_pkg::pend_t     pend,
    output logic               out_valid,
    output logic               resp_valid,
    output logic [7:0]         resp_byte,
    output logic               resp_last
);
    import piv_pkg::*;

    obj_t        obj_reg;
    logic [7:0]  start_reg;
    logic [8:0]  dlen_reg, pos_reg;
    logic [15:0] status_reg;
    logic        active_reg;
    pend_t       pend_reg;

    logic        ovalid_reg, rvalid_reg, rlast_reg;
    logic [7:0]  rbyte_reg;

    logic        rvalid_next, rlast_next;
    logic [7:0]  rbyte_next;

    assign pend = pend_reg;

    always_comb
    begin
        rvalid_next = active_reg;
        rbyte_next  = 8'h00;
        rlast_next  = 1'b0;
        if (active_reg) begin
            if (pos_reg < dlen_reg) begin
                rbyte_next = obj_byte(obj_reg, {2'b0, start_reg} + {1'b0, pos_reg},
                                      guid_high, guid_low);
            end else if (pos_reg == dlen_reg) begin
                rbyte_next = status_reg[15:8];
            end else begin
                rbyte_next = status_reg[7:0];
                rlast_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            obj_reg    <= OBJ_NONE;
            start_reg  <= '0;
            dlen_reg   <= '0;
            status_reg <= '0;
            pos_reg    <= '0;
            active_reg <= 1'b0;
            pend_reg   <= '0;
            ovalid_reg <= 1'b0;
            rvalid_reg <= 1'b0;
            rbyte_reg  <= '0;
            rlast_reg  <= 1'b0;
        end else begin
            if (dec.kill) begin
                active_reg <= 1'b0;
            end else if (dec.emit) begin
                obj_reg    <= dec.obj;
                start_reg  <= dec.start;
                dlen_reg   <= dec.len;
                status_reg <= dec.status;
                pos_reg    <= '0;
                active_reg <= 1'b1;
            end else if (rd && active_reg) begin
                if (rlast_next) begin
                    active_reg <= 1'b0;
                    pos_reg    <= '0;
                end else begin
                    pos_reg <= pos_reg + 9'd1;
                end
            end
            if (dec.pend_we) begin
                pend_reg <= dec.pend;
            end
            if (rd) begin
                ovalid_reg <= 1'b1;
                rvalid_reg <= rvalid_next;
                rbyte_reg  <= rbyte_next;
                rlast_reg  <= rlast_next;
            end else if (!out_stall) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = ovalid_reg;
    assign resp_valid = rvalid_reg;
    assign resp_byte  = rbyte_reg;
    assign resp_last  = rlast_reg;

endmodule

/* rtl/core/piv_apdu_responder.sv */
// PIV command APDU responder.
// A read item's result is registered and appears in the cycle after the item is accepted.
// Throughput: one item per cycle while the input is not stalled; a command's final byte is parsed in the same cycle.
// Input stall is raised only while a result waits in the output register.
// Reset (rst_n, async, active low) clears control state; capacity returns to 258.
module piv_apdu_responder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [7:0]  cmd_byte,
    input  logic        cmd_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        resp_valid,
    output logic [7:0]  resp_byte,
    output logic        resp_last,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import piv_pkg::*;

    localparam logic [1:0] REG_CAPACITY  = 2'd0;
    localparam logic [1:0] REG_GUID_HIGH = 2'd1;
    localparam logic [1:0] REG_GUID_LOW  = 2'd2;

    logic [12:0] capacity_reg;
    logic [63:0] guid_high_reg, guid_low_reg;

    logic      accept, wr, rd;
    decision_t dec;
    pend_t     pend;

    // one result slot: stall the input side only while it is held
    assign in_stall = out_valid & out_stall;
    assign accept   = in_valid & ~in_stall;
    assign wr       = accept & ~op;
    assign rd       = accept & op;

    // indexes past the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            capacity_reg  <= 13'd258;
            guid_high_reg <= '0;
            guid_low_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_CAPACITY:  capacity_reg  <= cfg_data[12:0];
                REG_GUID_HIGH: guid_high_reg <= cfg_data;
                REG_GUID_LOW:  guid_low_reg  <= cfg_data;
                default:       ;
            endcase
        end
    end

    // command capture and parse; decision valid on the final byte
    piv_cmd_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .cmd_byte (cmd_byte),
        .cmd_last (cmd_last),
        .capacity (capacity_reg),
        .pend     (pend),
        .dec      (dec)
    );

    // response state, chaining remainder and output register
    piv_readout u_readout (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd         (rd),
        .out_stall  (out_stall),
        .dec        (dec),
        .guid_high  (guid_high_reg),
        .guid_low   (guid_low_reg),
        .pend       (pend),
        .out_valid  (out_valid),
        .resp_valid (resp_valid),
        .resp_byte  (resp_byte),
        .resp_last  (resp_last)
    );

endmodule
